>>> hdl/dq_pkg.sv
// Shared types and constants for the double-ended queue checker.
`timescale 1ns / 1ps

package dq_pkg;

   localparam int Depth           = 1024;
   localparam int PtrWidth        = $clog2(Depth);
   localparam int CountWidth      = $clog2(Depth + 1);
   localparam int WordWidth       = 32;
   localparam int FillWidth       = 11;
   localparam int QueueDepth      = 2;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [WordWidth-1:0] AllOnes = '1;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_POP_FRONT  = 2'd1,
      CMD_PUSH_BACK  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_kind_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [WordWidth-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0]   popped_word;
      logic                   was_empty;
      logic                   push_dropped;
      logic                   matched;
      logic                   all_matched;
      logic [FillWidth-1:0]   fill_count;
   } rsp_type;

   typedef struct packed {
      op_kind_type            kind;
      logic                   is_pop;
      logic                   was_empty;
      logic                   push_dropped;
      logic [PtrWidth-1:0]    addr;
      logic [WordWidth-1:0]   value;
      logic [FillWidth-1:0]   fill_count;
   } entry_type;

endpackage

>>> hdl/dq_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module dq_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         write_data,
   output logic [Width-1:0]         read_data
);

   logic [Width-1:0] store_ff [Depth];
   logic [Width-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         store_ff[addr] <= write_data;
      end
      read_data_ff <= store_ff[addr];
   end

   assign read_data = read_data_ff;

endmodule

>>> hdl/dq_front.sv
// Front end: accepts commands, tracks pointers and count, classifies each transaction.
`timescale 1ns / 1ps

module dq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  dq_pkg::req_type   req,
   output dq_pkg::entry_type entry
);
   import dq_pkg::*;

   logic [PtrWidth-1:0]   front_ff, front_in;
   logic [PtrWidth-1:0]   back_ff, back_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  full;
   logic                  empty;

   function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(Depth - 1)) ? '0 : p + PtrWidth'(1);
   endfunction

   function automatic logic [PtrWidth-1:0] ptr_dec(input logic [PtrWidth-1:0] p);
      return (p == '0) ? PtrWidth'(Depth - 1) : p - PtrWidth'(1);
   endfunction

   assign full  = (count_ff == CountWidth'(Depth));
   assign empty = (count_ff == '0);

   always_comb begin
      front_in           = front_ff;
      back_in            = back_ff;
      count_in           = count_ff;
      entry.kind         = OP_NONE;
      entry.is_pop       = 1'b0;
      entry.was_empty    = 1'b0;
      entry.push_dropped = 1'b0;
      entry.addr         = front_ff;
      entry.value        = req.value;
      case (req.cmd)
         CMD_PUSH_FRONT: begin
            if (full) begin
               entry.push_dropped = 1'b1;
            end else begin
               entry.kind = OP_WRITE;
               entry.addr = front_ff;
               front_in   = ptr_inc(front_ff);
               count_in   = count_ff + CountWidth'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               entry.push_dropped = 1'b1;
            end else begin
               entry.kind = OP_WRITE;
               back_in    = ptr_dec(back_ff);
               entry.addr = back_in;
               count_in   = count_ff + CountWidth'(1);
            end
         end
         CMD_POP_FRONT: begin
            entry.is_pop = 1'b1;
            if (empty) begin
               entry.was_empty = 1'b1;
            end else begin
               entry.kind = OP_READ;
               front_in   = ptr_dec(front_ff);
               entry.addr = front_in;
               count_in   = count_ff - CountWidth'(1);
            end
         end
         CMD_POP_BACK: begin
            entry.is_pop = 1'b1;
            if (empty) begin
               entry.was_empty = 1'b1;
            end else begin
               entry.kind = OP_READ;
               entry.addr = back_ff;
               back_in    = ptr_inc(back_ff);
               count_in   = count_ff - CountWidth'(1);
            end
         end
         default: begin
            entry.kind = OP_NONE;
         end
      endcase
      entry.fill_count = FillWidth'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/dq_queue.sv
// Short queue of classified transactions between front and back ends.
`timescale 1ns / 1ps

module dq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dq_pkg::entry_type push_entry,
   output logic              full,
   output logic              pop_valid,
   output dq_pkg::entry_type pop_entry
);
   import dq_pkg::*;

   entry_type                  slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;

   function automatic logic [QueuePtrWidth-1:0] qptr_inc(
      input logic [QueuePtrWidth-1:0] p);
      return (p == QueuePtrWidth'(QueueDepth - 1)) ? '0 : p + QueuePtrWidth'(1);
   endfunction

   assign full      = (count_ff == QueueCountWidth'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? qptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_valid ? qptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QueueCountWidth'(push) - QueueCountWidth'(pop_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/dq_back.sv
// Back end: executes ring accesses, compares popped words, drives results.
`timescale 1ns / 1ps

module dq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              entry_valid,
   input  dq_pkg::entry_type entry,
   output logic              rsp_valid,
   output dq_pkg::rsp_type   rsp_data
);
   import dq_pkg::*;

   logic                 ram_write;
   logic [WordWidth-1:0] ram_read_data;
   logic                 stage_valid_ff;
   entry_type            stage_ff;
   logic [WordWidth-1:0] popped;
   logic                 match;
   logic                 sticky_ff, sticky_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   assign ram_write = entry_valid && (entry.kind == OP_WRITE);

   dq_ram #(
      .Width (WordWidth),
      .Depth (Depth)
   ) u_ring (
      .clock      (clock),
      .write_en   (ram_write),
      .addr       (entry.addr),
      .write_data (entry.value),
      .read_data  (ram_read_data)
   );

   always_comb begin
      case (stage_ff.kind)
         OP_READ:  popped = ram_read_data;
         OP_WRITE: popped = '0;
         OP_NONE:  popped = stage_ff.was_empty ? AllOnes : '0;
         default:  popped = '0;
      endcase
      match     = stage_ff.is_pop ? (popped == stage_ff.value) : 1'b1;
      sticky_in = sticky_ff & match;

      rsp_in.popped_word  = popped;
      rsp_in.was_empty    = stage_ff.was_empty;
      rsp_in.push_dropped = stage_ff.push_dropped;
      rsp_in.matched      = match;
      rsp_in.all_matched  = sticky_in;
      rsp_in.fill_count   = stage_ff.fill_count;
   end

   always_ff @(posedge clock) begin
      stage_ff <= entry;
      rsp_ff   <= rsp_in;
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         sticky_ff      <= 1'b1;
      end else begin
         stage_valid_ff <= entry_valid;
         rsp_valid_ff   <= stage_valid_ff;
         if (stage_valid_ff) begin
            sticky_ff <= sticky_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/double_ended_queue_checker.sv
// Double-ended queue of 32-bit words held in a ring, with pop checking.
// A transaction is taken at each rising edge where start is high and busy is low; one
// may be given every cycle. Every transaction produces exactly one result, shown for a
// single cycle with rsp_valid high after the queue slot, stage and result registers, and
// results come out in acceptance order. The receiver must take each result as it
// appears. The throughput figure of one transaction per cycle is set by the single port
// of the ring memory, which the back end uses once per transaction; the back end drains
// the two-entry queue every cycle, so busy only rises for back-to-back bursts longer
// than the queue if the back end were ever held, which it never is. Reads of ring
// entries return the word most recently pushed there; no clearing pass runs after reset.
`timescale 1ns / 1ps

module double_ended_queue_checker (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   output dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   logic      accept;
   entry_type front_entry;
   logic      queue_full;
   logic      back_valid;
   entry_type back_entry;

   assign busy   = queue_full;
   assign accept = start && !queue_full;

   dq_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .entry  (front_entry)
   );

   dq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop_valid  (back_valid),
      .pop_entry  (back_entry)
   );

   dq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (back_valid),
      .entry       (back_entry),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

>>> hdl/dq_checker.sv
// Port-level checks for the double-ended queue checker, bound to the top level.
`timescale 1ns / 1ps

module dq_checker (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input dq_pkg::req_type req_data,
   input logic            rsp_valid,
   input dq_pkg::rsp_type rsp_data
);
   import dq_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_empty |-> rsp_data.popped_word == AllOnes)
      else $error("empty pop did not return all ones");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.push_dropped |->
         rsp_data.matched && !rsp_data.was_empty && rsp_data.popped_word == '0)
      else $error("dropped push result malformed");

   a_mismatch_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |-> !rsp_data.all_matched)
      else $error("mismatch not reflected in sticky flag");

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.all_matched |=> !(rsp_valid && rsp_data.all_matched))
      else $error("sticky flag recovered");

endmodule

bind double_ended_queue_checker dq_checker u_dq_checker (.*);
